@@ rtl/mpr_pkg.sv @@
// Shared types and constants for the multi-peer reorder receiver.
package mpr_pkg;

    localparam int MAX_PEERS   = 8;
    localparam int SEQ_SPACE   = 64;
    localparam int MAX_PAYLOAD = 512;

    localparam int KEY_W  = 48;
    localparam int SEQ_W  = 7;
    localparam int TAG_W  = 16;
    localparam int LEN_W  = 10;
    localparam int KIND_W = 3;
    localparam int PEER_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CNT_W  = $clog2(MAX_PEERS + 1);
    localparam int IDX_W  = $clog2(SEQ_SPACE);
    localparam int ADDR_W = PEER_W + IDX_W;
    localparam int DESC_W = LEN_W + TAG_W;

    localparam int IN_W     = KEY_W + SEQ_W + TAG_W + LEN_W;
    localparam int IN_BYTES = (IN_W + 7) / 8;
    localparam int OUT_W     = PEER_W + SEQ_W + TAG_W + LEN_W;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RANGE   = 3'd4;

    localparam logic [SEQ_W-1:0] SEQ_END = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_RDROW,
        ST_PROC,
        ST_SCAN,
        ST_DRDAT,
        ST_ACK,
        ST_SINGLE
    } t_state;

    typedef struct packed {
        logic              hit;
        logic              full;
        logic [PEER_W-1:0] idx;
        logic [CNT_W-1:0]  count;
    } t_lookup;

endpackage

@@ rtl/mpr_peer_table.sv @@
// Peer key table: parallel key match and slot allocation.
module mpr_peer_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mpr_pkg::KEY_W-1:0] i_key,
    input  logic                      i_alloc,
    output mpr_pkg::t_lookup          o_lk
);
    import mpr_pkg::*;

    logic [KEY_W-1:0] r_keys [MAX_PEERS];
    logic [CNT_W-1:0] r_count;

    always_comb begin
        o_lk       = '0;
        o_lk.count = r_count;
        o_lk.full  = (r_count == CNT_W'(MAX_PEERS));
        o_lk.idx   = r_count[PEER_W-1:0];
        for (int i = MAX_PEERS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_count) && (r_keys[i] == i_key)) begin
                o_lk.hit = 1'b1;
                o_lk.idx = PEER_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_alloc) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_alloc) begin
            r_keys[r_count[PEER_W-1:0]] <= i_key;
        end
    end

`ifndef ASSERT_OFF
    a_no_alloc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_alloc |-> (r_count < CNT_W'(MAX_PEERS)))
        else $error("allocation with full table");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PEERS))
        else $error("peer count overflow");
    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_alloc |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("peer count did not advance");
`endif

endmodule

@@ rtl/multi_peer_reorder_receiver.sv @@
// Top level: multi-peer selective-repeat reorder receiver.
//   channel | dir | tdata fields (low bit up)                     | tuser | tlast
//   s       | in  | peer_key, seq_number, payload_tag, length     | -     | -
//   m       | out | peer_index, seq_out, tag_out, length_out      | kind  | last
// A data word passes LOOK, RDROW, PROC, SCAN and ACK, plus a DRDAT and SCAN pass per released
// descriptor; the drain reads the descriptor memory once per release.
// Closed and out-of-range words pass LOOK, RDROW and SINGLE; table-full words LOOK, SINGLE.
// Mark rows live in a memory with a registered read, read-modified-written once per data word.
// Reset clears the peer count and per-row mark valid bits; no clearing pass.
// A stalled output holds the sequencer in the state that emits the word.
module multi_peer_reorder_receiver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [mpr_pkg::IN_BYTES*8-1:0]    i_s_tdata,  // key, seq, tag, length
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [mpr_pkg::OUT_BYTES*8-1:0]   o_m_tdata,  // peer, seq, tag, length
    output logic [mpr_pkg::KIND_W-1:0]        o_m_tuser,  // kind
    output logic                              o_m_tlast
);
    import mpr_pkg::*;

    t_state r_state, n_state;

    logic [KEY_W-1:0]  r_key;
    logic [SEQ_W-1:0]  r_seq;
    logic [TAG_W-1:0]  r_tag;
    logic [LEN_W-1:0]  r_len;
    logic [PEER_W-1:0] r_peer;
    logic [KIND_W-1:0] r_skind;
    logic [SEQ_W-1:0]  r_exp;
    logic [SEQ_SPACE-1:0] r_row;
    logic              r_rdok;

    logic [SEQ_W-1:0]     r_nexp [MAX_PEERS];
    logic [SEQ_SPACE-1:0] r_mkmem [MAX_PEERS];
    logic [SEQ_SPACE-1:0] r_mkrd;
    logic [MAX_PEERS-1:0] r_mkv;
    logic [DESC_W-1:0]    r_stmem [MAX_PEERS*SEQ_SPACE];
    logic [DESC_W-1:0]    r_strd;

    logic              r_ovalid;
    logic [KIND_W-1:0] r_okind;
    logic [PEER_W-1:0] r_opeer;
    logic [SEQ_W-1:0]  r_oseq;
    logic [TAG_W-1:0]  r_otag;
    logic [LEN_W-1:0]  r_olen;
    logic              r_olast;

    t_lookup           lk;
    logic              s_acc, can_load, alloc;
    logic              st_we, st_re, mk_we;
    logic              seq_range, seq_marked, exp_more;
    logic [IDX_W-1:0]  seq_idx, exp_idx;
    logic [LEN_W-1:0]  in_len;

    mpr_peer_table u_peers (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_key),
        .i_alloc (alloc),
        .o_lk    (lk)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign can_load   = !r_ovalid || i_m_tready;
    assign in_len     = i_s_tdata[IN_W-1 -: LEN_W];
    assign seq_idx    = r_seq[IDX_W-1:0];
    assign exp_idx    = r_exp[IDX_W-1:0];
    assign seq_range  = r_seq[SEQ_W-1] || ({1'b0, r_seq} >= (SEQ_W+1)'(SEQ_SPACE));
    assign seq_marked = r_row[seq_idx];
    assign exp_more   = ({1'b0, r_exp} < (SEQ_W+1)'(SEQ_SPACE)) && r_row[exp_idx];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_acc) n_state = ST_LOOK;
            ST_LOOK:   n_state = (!lk.hit && lk.full) ? ST_SINGLE : ST_RDROW;
            ST_RDROW:  n_state = ((r_seq == SEQ_END) || seq_range) ? ST_SINGLE : ST_PROC;
            ST_PROC:   n_state = ST_SCAN;
            ST_SCAN:   n_state = exp_more ? ST_DRDAT : ST_ACK;
            ST_DRDAT:  if (can_load) n_state = ST_SCAN;
            ST_ACK:    if (can_load) n_state = ST_IDLE;
            ST_SINGLE: if (can_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        alloc = (r_state == ST_LOOK) && !lk.hit && !lk.full;
        st_we = (r_state == ST_PROC) && !seq_marked;
        st_re = (r_state == ST_SCAN) && exp_more;
        mk_we = (r_state == ST_ACK) && can_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_key <= i_s_tdata[KEY_W-1:0];
            r_seq <= i_s_tdata[KEY_W +: SEQ_W];
            r_tag <= i_s_tdata[KEY_W+SEQ_W +: TAG_W];
            r_len <= (in_len > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : in_len;
        end
        if (r_state == ST_LOOK) begin
            r_peer  <= lk.idx;
            r_rdok  <= lk.hit && r_mkv[lk.idx];
            r_skind <= KIND_FULL;
            r_mkrd  <= r_mkmem[lk.idx];
        end
        if (r_state == ST_RDROW) begin
            r_row   <= r_rdok ? r_mkrd : '0;
            r_exp   <= r_nexp[r_peer];
            r_skind <= (r_seq == SEQ_END) ? KIND_CLOSED : KIND_RANGE;
        end
        if (r_state == ST_PROC) begin
            if (r_seq == '0) begin
                r_exp <= SEQ_W'(1);
            end
            r_row[seq_idx] <= 1'b1;
        end
        if (st_re) begin
            r_row[exp_idx] <= 1'b0;
        end
        if ((r_state == ST_DRDAT) && can_load) begin
            r_exp <= r_exp + SEQ_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_nexp[lk.idx] <= SEQ_W'(1);
        end else if (mk_we) begin
            r_nexp[r_peer] <= r_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            r_mkmem[r_peer] <= r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mkv <= '0;
        end else if (mk_we) begin
            r_mkv[r_peer] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stmem[{r_peer, seq_idx}] <= {r_len, r_tag};
        end
        if (st_re) begin
            r_strd <= r_stmem[{r_peer, exp_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (can_load) begin
            r_ovalid <= (r_state == ST_DRDAT) || (r_state == ST_ACK) ||
                        (r_state == ST_SINGLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            if (r_state == ST_DRDAT) begin
                r_okind <= KIND_RELEASE;
                r_opeer <= r_peer;
                r_oseq  <= r_exp;
                r_otag  <= r_strd[TAG_W-1:0];
                r_olen  <= r_strd[DESC_W-1 -: LEN_W];
                r_olast <= 1'b0;
            end else begin
                r_okind <= (r_state == ST_ACK) ? KIND_ACK : r_skind;
                r_opeer <= (r_state == ST_SINGLE && r_skind == KIND_FULL) ? '0 : r_peer;
                r_oseq  <= r_seq;
                r_otag  <= '0;
                r_olen  <= '0;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {{(OUT_BYTES*8-OUT_W){1'b0}}, r_olen, r_otag, r_oseq, r_opeer};

`ifndef ASSERT_OFF
    a_peer_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROC) |-> ({1'b0, r_peer} < lk.count))
        else $error("working on an unallocated peer");
    a_release_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_RELEASE)) |-> !o_m_tlast)
        else $error("release marked last");
    a_store_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(st_we && st_re))
        else $error("descriptor store read and write together");
    a_drain_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DRDAT) && can_load) |=> (r_state == ST_SCAN))
        else $error("drain did not return to scan");
`endif

endmodule

@@ test/multi_peer_reorder_receiver_tb.sv @@
// Self-checking testbench for the multi-peer selective-repeat reorder receiver.
`timescale 1ns / 100ps

module multi_peer_reorder_receiver_tb;
    import mpr_pkg::*;

    localparam int N_RANDOM   = 90;
    localparam int SETTLE_CYC = 200;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PEER_W-1:0] peer;
        logic [SEQ_W-1:0]  seq;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_result;

    typedef struct {
        logic [KEY_W-1:0]  key;
        logic [SEQ_W-1:0]  seq;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        bit                typed;
        logic [KIND_W-1:0] kind_exp;
        logic [PEER_W-1:0] peer_exp;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [IN_BYTES*8-1:0]   i_s_tdata = '0;  // key, seq, tag, length
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_BYTES*8-1:0]  o_m_tdata;       // peer, seq, tag, length
    logic [KIND_W-1:0]       o_m_tuser;       // kind
    logic                    o_m_tlast;

    multi_peer_reorder_receiver u_top (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [KEY_W-1:0] pr_keys [MAX_PEERS];
    int               pr_count;
    int               pr_next [MAX_PEERS];
    bit               pr_mark [MAX_PEERS][SEQ_SPACE];
    logic [TAG_W-1:0] pr_tag  [MAX_PEERS][SEQ_SPACE];
    logic [LEN_W-1:0] pr_len  [MAX_PEERS][SEQ_SPACE];

    t_result expected_results[$];
    int      errors = 0;
    logic [KEY_W-1:0] key_pool [MAX_PEERS + 2];

    task automatic report(input string what);
        errors++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    function automatic t_result mk(input logic [KIND_W-1:0] k, input int p,
                                   input logic [SEQ_W-1:0] s,
                                   input logic [TAG_W-1:0] t,
                                   input logic [LEN_W-1:0] l);
        t_result r;
        r.kind = k; r.peer = p[PEER_W-1:0]; r.seq = s;
        r.tag = t; r.len = l; r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_receive(input logic [KEY_W-1:0] key,
                                   input logic [SEQ_W-1:0] seq,
                                   input logic [TAG_W-1:0] tag,
                                   input logic [LEN_W-1:0] len);
        int p;
        int s;
        int e;
        t_result q[$];
        p = -1;
        s = $signed(seq);
        for (int i = 0; i < pr_count; i++)
            if (p < 0 && pr_keys[i] == key) p = i;
        if (p < 0) begin
            if (pr_count >= MAX_PEERS) begin
                q.push_back(mk(KIND_FULL, 0, seq, '0, '0));
            end else begin
                p = pr_count++;
                pr_keys[p] = key;
                pr_next[p] = 1;
                for (int j = 0; j < SEQ_SPACE; j++) pr_mark[p][j] = 0;
            end
        end
        if (q.size() == 0) begin
            if (s == -1) begin
                q.push_back(mk(KIND_CLOSED, p, seq, '0, '0));
            end else if (s < 0 || s >= SEQ_SPACE) begin
                q.push_back(mk(KIND_RANGE, p, seq, '0, '0));
            end else begin
                if (s == 0) pr_next[p] = 1;
                if (!pr_mark[p][s]) begin
                    pr_mark[p][s] = 1;
                    pr_tag[p][s] = tag;
                    pr_len[p][s] = (len > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : len;
                end
                while (pr_next[p] < SEQ_SPACE && pr_mark[p][pr_next[p]]) begin
                    e = pr_next[p];
                    q.push_back(mk(KIND_RELEASE, p, SEQ_W'(e), pr_tag[p][e], pr_len[p][e]));
                    pr_mark[p][e] = 0;
                    pr_next[p] = e + 1;
                end
                q.push_back(mk(KIND_ACK, p, seq, '0, '0));
            end
        end
        q[q.size() - 1].last = 1'b1;
        foreach (q[i]) expected_results.push_back(q[i]);
    endtask

    // receiver: stall pattern, check on rising edge
    int stall_phase = 0;
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = mk(o_m_tuser, o_m_tdata[PEER_W-1:0],
                     o_m_tdata[PEER_W +: SEQ_W], o_m_tdata[PEER_W+SEQ_W +: TAG_W],
                     o_m_tdata[PEER_W+SEQ_W+TAG_W +: LEN_W]);
            got.last = o_m_tlast;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected word kind %0d seq %0d", got.kind, got.seq));
            end else begin
                want = expected_results.pop_front();
                if (got.kind != want.kind)
                    report($sformatf("kind %0d want %0d", got.kind, want.kind));
                if (got.peer != want.peer)
                    report($sformatf("peer %0d want %0d", got.peer, want.peer));
                if (got.seq != want.seq)
                    report($sformatf("seq %0d want %0d", got.seq, want.seq));
                if (got.tag != want.tag)
                    report($sformatf("tag %h want %h", got.tag, want.tag));
                if (got.len != want.len)
                    report($sformatf("len %0d want %0d", got.len, want.len));
                if (got.last != want.last)
                    report($sformatf("last %0d want %0d", got.last, want.last));
            end
        end
    end

    always @(negedge i_clk) begin
        stall_phase = (stall_phase + 1) % 40;
        if (stall_phase < 15) i_m_tready <= 1'b1;
        else if (stall_phase < 25) i_m_tready <= ($urandom_range(0, 2) != 0);
        else i_m_tready <= ($urandom_range(0, 3) == 0);
    end

    int burst_left = 0;

    task automatic send_word(input logic [KEY_W-1:0] key, input logic [SEQ_W-1:0] seq,
                             input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
        end else begin
            gap = 0;
        end
        // the block does not accept again until it is back in idle anyway
        @(negedge i_clk);
        repeat (gap) @(negedge i_clk);
        burst_left--;
        i_s_tdata  <= (IN_BYTES*8)'({len, tag, seq, key});
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_receive(key, seq, tag, len);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic drain_wait();
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    t_row dir_rows [$];

    function automatic t_row row(input logic [KEY_W-1:0] k, input int s,
                                 input logic [TAG_W-1:0] t, input logic [LEN_W-1:0] l,
                                 input bit typed = 0,
                                 input logic [KIND_W-1:0] kx = KIND_ACK,
                                 input int px = 0);
        t_row r;
        r.key = k; r.seq = SEQ_W'(s); r.tag = t; r.len = l;
        r.typed = typed; r.kind_exp = kx; r.peer_exp = PEER_W'(px);
        return r;
    endfunction

    initial begin
        int r;
        int p;
        int s;
        t_row d;
        pr_count = 0;
        for (int i = 0; i < MAX_PEERS + 2; i++)
            key_pool[i] = {$urandom(), 16'($urandom())};
        key_pool[0] = '0;
        key_pool[1] = '1;

        // directed table
        dir_rows.push_back(row(key_pool[0], 1, 16'hFFFF, 10'd1023, 0));
        dir_rows.push_back(row(key_pool[0], -1, 0, 0, 1, KIND_CLOSED, 0));
        dir_rows.push_back(row(key_pool[0], 3, 16'h0000, 10'd0));
        dir_rows.push_back(row(key_pool[0], 3, 16'h1234, 10'd5));
        dir_rows.push_back(row(key_pool[0], 2, 16'hAAAA, 10'd512));
        dir_rows.push_back(row(key_pool[0], -64, 0, 0, 1, KIND_RANGE, 0));
        dir_rows.push_back(row(key_pool[0], -2, 0, 0, 1, KIND_RANGE, 0));
        dir_rows.push_back(row(key_pool[1], 63, 16'h5555, 10'd513));
        dir_rows.push_back(row(key_pool[1], 0, 16'h0001, 10'd10));
        dir_rows.push_back(row(key_pool[0], 1, 16'h7777, 10'd7));
        dir_rows.push_back(row(key_pool[0], 0, 16'h8888, 10'd8));
        dir_rows.push_back(row(key_pool[1], 62, 16'h3333, 10'd300));
        for (int i = 2; i < MAX_PEERS; i++)
            dir_rows.push_back(row(key_pool[i], 1, 16'(i), 10'(i)));
        dir_rows.push_back(row(key_pool[MAX_PEERS], 5, 0, 0, 1, KIND_FULL, 0));
        dir_rows.push_back(row(key_pool[MAX_PEERS + 1], -1, 0, 0, 1, KIND_FULL, 0));

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            d = dir_rows[i];
            send_word(d.key, d.seq, d.tag, d.len);
            if (d.typed) begin
                // predictor gave one word; cross-check against the table
                t_result w;
                w = expected_results[expected_results.size() - 1];
                if (w.kind != d.kind_exp || w.peer != d.peer_exp)
                    report($sformatf("table row %0d disagrees with predictor", i));
            end
        end
        drain_wait();
        repeat ($urandom_range(5, 30)) @(negedge i_clk);

        // random: mostly in-window data for known peers, some noise
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            p = $urandom_range(0, MAX_PEERS - 1);
            if (r < 70) s = (pr_next[p] < SEQ_SPACE) ?
                            $urandom_range(pr_next[p], (pr_next[p] + 6 < SEQ_SPACE) ?
                                           pr_next[p] + 6 : SEQ_SPACE - 1) : 0;
            else if (r < 78) s = 0;
            else if (r < 83) s = -1;
            else if (r < 90) s = $signed(7'($urandom_range(64, 126)));
            else s = $urandom_range(1, SEQ_SPACE - 1);
            send_word((r % 17 == 0) ? {$urandom(), 16'($urandom())} : key_pool[p],
                      SEQ_W'(s), 16'($urandom()), 10'($urandom()));
            if (n == N_RANDOM / 2) drain_wait();
        end

        drain_wait();
        repeat (SETTLE_CYC) @(negedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mpr_pkg.sv
rtl/mpr_peer_table.sv
rtl/multi_peer_reorder_receiver.sv
test/multi_peer_reorder_receiver_tb.sv
